// ===== rtl/core/sdpfx_pkg.sv =====
// ----------------------------------------------------------------------------
// SDP field extractor package
// Shared types, character codes, prefix tables and divider constants.
// ----------------------------------------------------------------------------
package sdpfx_pkg;

  localparam int unsigned AddrTextMax = 15;

  localparam logic [7:0] ChLf    = 8'h0A;
  localparam logic [7:0] ChCr    = 8'h0D;
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChDot   = 8'h2E;
  localparam logic [7:0] ChSlash = 8'h2F;
  localparam logic [7:0] ChZero  = 8'h30;
  localparam logic [7:0] ChNine  = 8'h39;
  localparam logic [7:0] ChEq    = 8'h3D;
  localparam logic [7:0] ChUpL   = 8'h4C;
  localparam logic [7:0] ChA     = 8'h61;
  localparam logic [7:0] ChC     = 8'h63;
  localparam logic [7:0] ChM     = 8'h6D;
  localparam logic [7:0] ChO     = 8'h6F;

  localparam logic [6:0]  FractionStart = 7'd100;
  localparam logic [15:0] UsPerMs       = 16'd1000;
  // floor(x / 1e6) == (x * RecipMul) >> RecipShift for every 32-bit x
  localparam logic [30:0] RecipMul      = 31'd1125899907;
  localparam int unsigned RecipShift    = 50;

  localparam logic [3:0] PhaseStart     = 4'd0;
  localparam logic [3:0] PhaseSecond    = 4'd1;
  localparam logic [3:0] PhaseDepth     = 4'd2;
  localparam logic [3:0] PhaseRate      = 4'd3;
  localparam logic [3:0] PhaseChan      = 4'd4;
  localparam logic [3:0] PhaseDone      = 4'd5;
  localparam logic [3:0] PhaseInAddr    = 4'd7;
  localparam logic [3:0] PhaseAfterSlash = 4'd8;

  typedef enum logic [2:0] {
    KIND_NONE, KIND_O, KIND_C, KIND_M, KIND_A
  } line_kind_e;

  typedef enum logic [2:0] {
    BODY_NONE, BODY_PORT, BODY_RTPMAP, BODY_SSRC, BODY_PTIME, BODY_DOMAIN, BODY_SYNC
  } body_kind_e;

  typedef struct packed {
    logic [31:0] origin_address;
    logic [31:0] connection_address;
    logic [15:0] media_port;
    logic [7:0]  sample_bits;
    logic [31:0] sample_rate_hz;
    logic [7:0]  channel_total;
    logic [31:0] ssrc_value;
    logic [15:0] packet_samples;
    logic [7:0]  clock_domain;
    logic        clock_domain_seen;
    logic [31:0] sync_timestamp;
    logic        sync_time_seen;
  } fields_t;

  function automatic logic [4:0] prefix_size(input logic [2:0] k);
    logic [4:0] n;
    case (k)
      3'd0:    n = 5'd6;
      3'd1:    n = 5'd7;
      3'd2:    n = 5'd5;
      3'd3:    n = 5'd6;
      3'd4:    n = 5'd19;
      3'd5:    n = 5'd10;
      default: n = 5'd0;
    endcase
    return n;
  endfunction

  function automatic logic [7:0] prefix_char(input logic [2:0] k, input logic [4:0] i);
    logic [8*19-1:0] txt;
    logic [4:0]      idx;
    case (k)
      3'd0:    txt = {"audio ", {13{8'h00}}};
      3'd1:    txt = {"rtpmap:", {12{8'h00}}};
      3'd2:    txt = {"ssrc:", {14{8'h00}}};
      3'd3:    txt = {"ptime:", {13{8'h00}}};
      3'd4:    txt = "clock-domain:PTPv2 ";
      3'd5:    txt = {"sync-time:", {9{8'h00}}};
      default: txt = '0;
    endcase
    idx = 5'd18 - i;
    if (i > 5'd18) begin
      return 8'h00;
    end
    return txt[8*idx +: 8];
  endfunction

  function automatic logic [7:0] marker_char(input logic [2:0] i);
    logic [8*7-1:0] txt;
    logic [2:0]     idx;
    txt = "IN IP4 ";
    idx = 3'd6 - i;
    if (i > 3'd6) begin
      return 8'h00;
    end
    return txt[8*idx +: 8];
  endfunction

endpackage

// ===== rtl/core/sdpfx_if.sv =====
// ----------------------------------------------------------------------------
// SDP field extractor channels
// Text request channel and result request channel, valid/ready handshake.
// ----------------------------------------------------------------------------
interface sdpfx_text_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_char;
  logic       end_of_text;

  modport source (output valid, text_char, end_of_text, input ready);
  modport sink   (input valid, text_char, end_of_text, output ready);
endinterface

interface sdpfx_result_if;
  logic        valid;
  logic        ready;
  logic [31:0] origin_address;
  logic [31:0] connection_address;
  logic [15:0] media_port;
  logic [7:0]  sample_bits;
  logic [31:0] sample_rate_hz;
  logic [7:0]  channel_total;
  logic [31:0] ssrc_value;
  logic [15:0] packet_samples;
  logic [7:0]  clock_domain;
  logic        clock_domain_seen;
  logic [31:0] sync_timestamp;
  logic        sync_time_seen;

  modport source (output valid, origin_address, connection_address, media_port,
                  sample_bits, sample_rate_hz, channel_total, ssrc_value,
                  packet_samples, clock_domain, clock_domain_seen,
                  sync_timestamp, sync_time_seen, input ready);
  modport sink   (input valid, origin_address, connection_address, media_port,
                  sample_bits, sample_rate_hz, channel_total, ssrc_value,
                  packet_samples, clock_domain, clock_domain_seen,
                  sync_timestamp, sync_time_seen, output ready);
endinterface

// ===== rtl/core/sdpfx_parser.sv =====
// ----------------------------------------------------------------------------
// SDP field extractor parser
// One character per cycle while advance_i is high: line splitting, prefix matching, number and
// address accumulation; snapshots the fields on the final character.
// ----------------------------------------------------------------------------
module sdpfx_parser (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                advance_i,
  input  logic                valid_i,
  input  logic [7:0]          char_i,
  input  logic                last_i,
  output logic                valid_o,
  output sdpfx_pkg::fields_t  fields_o
);

  typedef struct packed {
    logic                   held;
    logic [4:0]             pos;
    sdpfx_pkg::line_kind_e  kind;
    logic [3:0]             phase;
    logic [5:0]             hits;
    sdpfx_pkg::body_kind_e  body;
    logic [15:0]            num;
    logic [9:0]             frac;
    logic [6:0]             scale;
    logic [23:0]            dotted;
    logic [8:0]             octet;
    logic [1:0]             dots;
    logic                   addr_ok;
    logic                   grp;
    logic [4:0]             tlen;
    sdpfx_pkg::fields_t     f;
  } pstate_t;

  function automatic pstate_t reset_state();
    pstate_t s;
    s         = '0;
    s.kind    = sdpfx_pkg::KIND_NONE;
    s.body    = sdpfx_pkg::BODY_NONE;
    s.scale   = sdpfx_pkg::FractionStart;
    s.addr_ok = 1'b1;
    return s;
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= sdpfx_pkg::ChZero) && (c <= sdpfx_pkg::ChNine);
  endfunction

  function automatic pstate_t token_clear(input pstate_t s);
    s.dotted  = '0;
    s.octet   = '0;
    s.dots    = '0;
    s.addr_ok = 1'b1;
    s.grp     = 1'b0;
    s.tlen    = '0;
    return s;
  endfunction

  function automatic pstate_t token_feed(input pstate_t s, input logic [7:0] c);
    logic [11:0] oct;
    oct = {3'b000, s.octet} * 12'd10 + {8'h00, c[3:0]};
    if (s.tlen != 5'd31) begin
      s.tlen = s.tlen + 5'd1;
    end
    if (is_digit(c)) begin
      if (oct > 12'd255) begin
        s.addr_ok = 1'b0;
        s.octet   = 9'd256;
      end else begin
        s.octet = oct[8:0];
      end
      s.grp = 1'b1;
    end else if (c == sdpfx_pkg::ChDot && s.grp && s.dots != 2'd3) begin
      s.dotted = {s.dotted[15:0], s.octet[7:0]};
      s.dots   = s.dots + 2'd1;
      s.octet  = '0;
      s.grp    = 1'b0;
    end else begin
      s.addr_ok = 1'b0;
    end
    return s;
  endfunction

  function automatic logic token_ok(input pstate_t s);
    return s.addr_ok && s.dots == 2'd3 && s.grp &&
           s.tlen <= 5'(sdpfx_pkg::AddrTextMax);
  endfunction

  function automatic pstate_t body_start(input pstate_t s, input sdpfx_pkg::body_kind_e b);
    s.body  = b;
    s.phase = sdpfx_pkg::PhaseStart;
    s.hits  = '0;
    case (b)
      sdpfx_pkg::BODY_PORT: s.f.media_port = '0;
      sdpfx_pkg::BODY_SSRC: s.f.ssrc_value = '0;
      sdpfx_pkg::BODY_PTIME: begin
        s.num              = '0;
        s.frac             = '0;
        s.scale            = sdpfx_pkg::FractionStart;
        s.f.packet_samples = '0;
      end
      sdpfx_pkg::BODY_DOMAIN: begin
        s.f.clock_domain      = '0;
        s.f.clock_domain_seen = 1'b1;
      end
      sdpfx_pkg::BODY_SYNC: begin
        s.f.sync_timestamp = '0;
        s.f.sync_time_seen = 1'b1;
      end
      default: ;
    endcase
    return s;
  endfunction

  function automatic pstate_t body_feed(input pstate_t s, input logic [7:0] c);
    logic       dg;
    logic [3:0] d;
    logic [9:0] fr;
    dg = is_digit(c);
    d  = dg ? c[3:0] : 4'd0;
    fr = 10'(d) * 10'(s.scale);
    case (s.body)
      sdpfx_pkg::BODY_RTPMAP: begin
        if (s.phase == sdpfx_pkg::PhaseStart && dg) begin
          // payload type digits: skip
        end else if (s.phase == sdpfx_pkg::PhaseStart && c == sdpfx_pkg::ChSpace) begin
          s.phase = sdpfx_pkg::PhaseSecond;
        end else if (s.phase == sdpfx_pkg::PhaseStart || s.phase == sdpfx_pkg::PhaseSecond) begin
          if (c == sdpfx_pkg::ChUpL) begin
            s.f.sample_bits    = '0;
            s.f.sample_rate_hz = '0;
            s.f.channel_total  = '0;
            s.phase            = sdpfx_pkg::PhaseDepth;
          end else begin
            s.phase = sdpfx_pkg::PhaseDone;
          end
        end else if (s.phase == sdpfx_pkg::PhaseDepth || s.phase == sdpfx_pkg::PhaseRate ||
                     s.phase == sdpfx_pkg::PhaseChan) begin
          if (dg) begin
            if (s.phase == sdpfx_pkg::PhaseDepth) begin
              s.f.sample_bits = s.f.sample_bits * 8'd10 + 8'(d);
            end else if (s.phase == sdpfx_pkg::PhaseRate) begin
              s.f.sample_rate_hz = s.f.sample_rate_hz * 32'd10 + 32'(d);
            end else begin
              s.f.channel_total = s.f.channel_total * 8'd10 + 8'(d);
            end
          end else if (c == sdpfx_pkg::ChSlash && s.phase != sdpfx_pkg::PhaseChan) begin
            s.phase = s.phase + 4'd1;
          end else begin
            s.phase = sdpfx_pkg::PhaseDone;
          end
        end
      end
      sdpfx_pkg::BODY_PTIME: begin
        if (s.phase == sdpfx_pkg::PhaseStart) begin
          if (dg) begin
            s.num = s.num * 16'd10 + 16'(d);
          end else begin
            s.phase = (c == sdpfx_pkg::ChDot) ? sdpfx_pkg::PhaseSecond : sdpfx_pkg::PhaseDone;
          end
        end else if (s.phase == sdpfx_pkg::PhaseSecond) begin
          if (dg && s.scale != 7'd0) begin
            s.frac = s.frac + fr;
            case (s.scale)
              7'd100:  s.scale = 7'd10;
              7'd10:   s.scale = 7'd1;
              default: s.scale = 7'd0;
            endcase
          end else begin
            s.phase = sdpfx_pkg::PhaseDone;
          end
        end
        s.f.packet_samples = s.num * sdpfx_pkg::UsPerMs + 16'(s.frac);
      end
      sdpfx_pkg::BODY_PORT, sdpfx_pkg::BODY_SSRC, sdpfx_pkg::BODY_DOMAIN,
      sdpfx_pkg::BODY_SYNC: begin
        if (s.phase == sdpfx_pkg::PhaseStart) begin
          if (!dg) begin
            s.phase = sdpfx_pkg::PhaseDone;
          end else if (s.body == sdpfx_pkg::BODY_PORT) begin
            s.f.media_port = s.f.media_port * 16'd10 + 16'(d);
          end else if (s.body == sdpfx_pkg::BODY_SSRC) begin
            s.f.ssrc_value = s.f.ssrc_value * 32'd10 + 32'(d);
          end else if (s.body == sdpfx_pkg::BODY_DOMAIN) begin
            s.f.clock_domain = s.f.clock_domain * 8'd10 + 8'(d);
          end else begin
            s.f.sync_timestamp = s.f.sync_timestamp * 32'd10 + 32'(d);
          end
        end
      end
      default: ;
    endcase
    return s;
  endfunction

  function automatic pstate_t value_char(input pstate_t s, input logic [7:0] c,
                                         input logic [4:0] vi);
    logic [3:0]            ph;
    logic                  done;
    logic                  start;
    logic                  feed;
    sdpfx_pkg::body_kind_e nb;
    logic [4:0]            len;
    done  = 1'b0;
    start = 1'b0;
    feed  = 1'b0;
    nb    = sdpfx_pkg::BODY_NONE;
    ph    = s.phase;
    case (s.kind)
      sdpfx_pkg::KIND_O: begin
        if (c == sdpfx_pkg::ChSpace) s = token_clear(s);
        else s = token_feed(s, c);
      end
      sdpfx_pkg::KIND_C: begin
        if (s.phase < sdpfx_pkg::PhaseInAddr) begin
          // fall back along the marker on mismatch
          for (int i = 0; i < 2; i++) begin
            if (ph != 4'd0 && c != sdpfx_pkg::marker_char(ph[2:0])) begin
              ph = (ph == 4'd4) ? 4'd1 : 4'd0;
            end
          end
          if (c == sdpfx_pkg::marker_char(ph[2:0])) ph = ph + 4'd1;
          s.phase = ph;
          if (ph == sdpfx_pkg::PhaseInAddr) s = token_clear(s);
        end else if (s.phase == sdpfx_pkg::PhaseInAddr) begin
          if (c == sdpfx_pkg::ChSlash) s.phase = sdpfx_pkg::PhaseAfterSlash;
          else s = token_feed(s, c);
        end
      end
      sdpfx_pkg::KIND_M, sdpfx_pkg::KIND_A: begin
        if (s.body != sdpfx_pkg::BODY_NONE) begin
          s = body_feed(s, c);
        end else begin
          for (int k = 0; k < 6; k++) begin
            len = sdpfx_pkg::prefix_size(3'(k));
            if (!done && s.hits[k]) begin
              if (vi < len) begin
                if (c != sdpfx_pkg::prefix_char(3'(k), vi)) begin
                  s.hits[k] = 1'b0;
                end else if (k == 4 && vi + 5'd1 == len) begin
                  start = 1'b1;
                  nb    = sdpfx_pkg::BODY_DOMAIN;
                  done  = 1'b1;
                end
              end else if (vi == len) begin
                start = 1'b1;
                feed  = 1'b1;
                nb    = sdpfx_pkg::body_kind_e'(3'(k + 1));
                done  = 1'b1;
              end
            end
          end
          if (start) s = body_start(s, nb);
          if (feed) s = body_feed(s, c);
        end
      end
      default: ;
    endcase
    return s;
  endfunction

  function automatic pstate_t line_char(input pstate_t s, input logic [7:0] c);
    if (s.pos == 5'd0) begin
      case (c)
        sdpfx_pkg::ChO: s.kind = sdpfx_pkg::KIND_O;
        sdpfx_pkg::ChC: s.kind = sdpfx_pkg::KIND_C;
        sdpfx_pkg::ChM: s.kind = sdpfx_pkg::KIND_M;
        sdpfx_pkg::ChA: s.kind = sdpfx_pkg::KIND_A;
        default:        s.kind = sdpfx_pkg::KIND_NONE;
      endcase
      s.hits = (s.kind == sdpfx_pkg::KIND_M) ? 6'h01 :
               (s.kind == sdpfx_pkg::KIND_A) ? 6'h3E : 6'h00;
    end else if (s.pos == 5'd1) begin
      if (c != sdpfx_pkg::ChEq) s.kind = sdpfx_pkg::KIND_NONE;
    end else if (s.kind != sdpfx_pkg::KIND_NONE) begin
      s = value_char(s, c, s.pos - 5'd2);
    end
    if (s.pos != 5'd31) s.pos = s.pos + 5'd1;
    return s;
  endfunction

  function automatic pstate_t line_end(input pstate_t s);
    if (s.pos >= 5'd2) begin
      if (s.kind == sdpfx_pkg::KIND_O && token_ok(s)) begin
        s.f.origin_address = {s.dotted, s.octet[7:0]};
      end else if (s.kind == sdpfx_pkg::KIND_C && s.phase >= sdpfx_pkg::PhaseInAddr &&
                   token_ok(s)) begin
        s.f.connection_address = {s.dotted, s.octet[7:0]};
      end
    end
    s.pos   = '0;
    s.kind  = sdpfx_pkg::KIND_NONE;
    s.phase = sdpfx_pkg::PhaseStart;
    s.hits  = '0;
    s.body  = sdpfx_pkg::BODY_NONE;
    s       = token_clear(s);
    return s;
  endfunction

  pstate_t            state_q, state_d;
  sdpfx_pkg::fields_t snap_d, fields_q;
  logic               valid_q;

  always_comb begin
    state_d = state_q;
    // a held CR that is not followed by LF is plain text
    if (state_q.held && char_i != sdpfx_pkg::ChLf) begin
      state_d.held = 1'b0;
      state_d      = line_char(state_d, sdpfx_pkg::ChCr);
    end
    state_d.held = 1'b0;
    if (char_i == sdpfx_pkg::ChLf) begin
      state_d = line_end(state_d);
    end else if (char_i == sdpfx_pkg::ChCr) begin
      state_d.held = 1'b1;
    end else begin
      state_d = line_char(state_d, char_i);
    end
    snap_d = state_d.f;
    if (last_i) begin
      state_d.held = 1'b0;
      state_d      = line_end(state_d);
      snap_d       = state_d.f;
      state_d      = reset_state();
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= reset_state();
      valid_q <= 1'b0;
    end else if (advance_i) begin
      valid_q <= valid_i && last_i;
      if (valid_i) state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance_i) fields_q <= snap_d;
  end

  assign valid_o  = valid_q;
  assign fields_o = fields_q;

endmodule

// ===== rtl/core/sdpfx_samples.sv =====
// ----------------------------------------------------------------------------
// SDP field extractor samples-per-packet stage
// Two registered steps: ptime times rate, then divide by one million
// through a reciprocal multiply unless the rate is zero; holds the result register.
// ----------------------------------------------------------------------------
module sdpfx_samples (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                advance_i,
  input  logic                valid_i,
  input  sdpfx_pkg::fields_t  fields_i,
  output logic                valid_o,
  output sdpfx_pkg::fields_t  fields_o
);

  logic [47:0]        prod_full;
  logic [62:0]        quo_full;
  logic [31:0]        prod_q;
  logic               prod_valid_q;
  sdpfx_pkg::fields_t prod_fields_q;
  sdpfx_pkg::fields_t out_d, out_q;
  logic               out_valid_q;

  assign prod_full = {32'h0, fields_i.packet_samples} * {16'h0, fields_i.sample_rate_hz};
  assign quo_full  = {31'h0, prod_q} * {32'h0, sdpfx_pkg::RecipMul};

  always_comb begin
    out_d = prod_fields_q;
    if (prod_fields_q.sample_rate_hz != 32'd0) begin
      out_d.packet_samples = 16'(quo_full[62:sdpfx_pkg::RecipShift]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else if (advance_i) begin
      prod_valid_q <= valid_i;
      out_valid_q  <= prod_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance_i) begin
      prod_q        <= prod_full[31:0];
      prod_fields_q <= fields_i;
      out_q         <= out_d;
    end
  end

  assign valid_o  = out_valid_q;
  assign fields_o = out_q;

endmodule

// ===== rtl/core/sdp_stream_field_extractor_core.sv =====
// ----------------------------------------------------------------------------
// SDP stream field extractor
// Parses session-description text one character per cycle while not stalled and returns
// the addresses, port, audio format and clock attributes it carries.
// ----------------------------------------------------------------------------
// Usage:
//   text_i carries one character per request plus an end_of_text flag on
//   the final character. result_o carries one request per text, issued
//   only for the character flagged end_of_text.
//   Throughput: one character per cycle whenever the pipeline advances, with
//   no gaps between texts. The final character passes through the input
//   register, parse step, product step and reciprocal-divide step feeding
//   the result register.
//   Pipeline depth is set by the samples-per-packet arithmetic: one
//   16x32 multiply and one 32x31 multiply, each in its own stage.
//   Stall: the whole pipeline advances together; while a result sits in
//   the result register unaccepted, every stage holds and text_i.ready
//   stays low. An empty result register lets the text keep flowing.
//   Reset: asynchronous, active low; clears the parse state with its
//   collected fields and every valid flag. No clearing pass is needed.
// ----------------------------------------------------------------------------
module sdp_stream_field_extractor_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  sdpfx_text_if.sink    text_i,
  sdpfx_result_if.source result_o
);

  logic               advance;
  logic               in_valid_q;
  logic [7:0]         in_char_q;
  logic               in_last_q;
  logic               parse_valid;
  sdpfx_pkg::fields_t parse_fields;
  logic               res_valid;
  sdpfx_pkg::fields_t res_fields;

  // advance when the result register is empty or being drained
  assign advance      = !res_valid || result_o.ready;
  assign text_i.ready = advance;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (advance) begin
      in_valid_q <= text_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      in_char_q <= text_i.text_char;
      in_last_q <= text_i.end_of_text;
    end
  end

  sdpfx_parser u_parser (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .advance_i (advance),
    .valid_i   (in_valid_q),
    .char_i    (in_char_q),
    .last_i    (in_last_q),
    .valid_o   (parse_valid),
    .fields_o  (parse_fields)
  );

  sdpfx_samples u_samples (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .advance_i (advance),
    .valid_i   (parse_valid),
    .fields_i  (parse_fields),
    .valid_o   (res_valid),
    .fields_o  (res_fields)
  );

  assign result_o.valid              = res_valid;
  assign result_o.origin_address     = res_fields.origin_address;
  assign result_o.connection_address = res_fields.connection_address;
  assign result_o.media_port         = res_fields.media_port;
  assign result_o.sample_bits        = res_fields.sample_bits;
  assign result_o.sample_rate_hz     = res_fields.sample_rate_hz;
  assign result_o.channel_total      = res_fields.channel_total;
  assign result_o.ssrc_value         = res_fields.ssrc_value;
  assign result_o.packet_samples     = res_fields.packet_samples;
  assign result_o.clock_domain       = res_fields.clock_domain;
  assign result_o.clock_domain_seen  = res_fields.clock_domain_seen;
  assign result_o.sync_timestamp     = res_fields.sync_timestamp;
  assign result_o.sync_time_seen     = res_fields.sync_time_seen;

`ifndef SYNTHESIS
  // a final character in the input register reaches the parse output next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && in_last_q && advance |=> parse_valid)
    else $error("final character did not produce a parse result");

  // the domain number is only set together with its seen flag
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid && !res_fields.clock_domain_seen |-> res_fields.clock_domain == 8'd0)
    else $error("clock domain set without seen flag");

  // the sync timestamp is only set together with its seen flag
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid && !res_fields.sync_time_seen |-> res_fields.sync_timestamp == 32'd0)
    else $error("sync timestamp set without seen flag");
`endif

endmodule
